// ===== rtl/gpwc_pkg.sv =====
`default_nettype none

package gpwc_pkg;

    // field widths
    localparam int STR_W      = 9;
    localparam int MIN_W      = 16;
    localparam int WIN_W      = 24;
    localparam int PW_W       = 16;
    localparam int CNT_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // capture stops after this many emitted pulses
    localparam int MAX_PULSE_COUNT = 256;

    // result queue
    localparam int RQ_DEPTH  = 4;
    localparam int RQ_PTR_W  = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W  = $clog2(RQ_DEPTH + 1);

    // input mode codes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RSSI_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS    = 2'd2;

    // register reset values
    localparam logic signed [STR_W-1:0] RSSI_THRESHOLD_RST  = -9'sd80;
    localparam logic [MIN_W-1:0]        MIN_PULSE_TICKS_RST = 16'd100;
    localparam logic [WIN_W-1:0]        WINDOW_TICKS_RST    = 24'd500000;

    typedef enum logic [1:0] {
        KIND_REJECT = 2'd0,
        KIND_PULSE  = 2'd1,
        KIND_DONE   = 2'd2
    } t_kind;

    typedef struct packed {
        logic                    mode;
        logic signed [STR_W-1:0] strength_dbm;
        logic                    level;
    } t_item;

    typedef struct packed {
        t_kind                   kind;
        logic [PW_W-1:0]         pulse_width;
        logic [CNT_W-1:0]        pulse_count;
        logic signed [STR_W-1:0] strength_seen;
        logic                    last;
    } t_result;

    typedef struct packed {
        logic signed [STR_W-1:0] rssi_threshold;
        logic [MIN_W-1:0]        min_pulse_ticks;
        logic [WIN_W-1:0]        window_ticks;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/gpwc_in_if.sv =====
`default_nettype none

interface gpwc_in_if
    import gpwc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic signed [STR_W-1:0] strength_dbm;
    logic                    level;

    modport source (output valid, output mode, output strength_dbm, output level,
                    input ready);
    modport sink   (input valid, input mode, input strength_dbm, input level,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/gpwc_out_if.sv =====
`default_nettype none

interface gpwc_out_if
    import gpwc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              kind;
    logic [PW_W-1:0]         pulse_width;
    logic [CNT_W-1:0]        pulse_count;
    logic signed [STR_W-1:0] strength_seen;
    logic                    last;

    modport source (output valid, output kind, output pulse_width, output pulse_count,
                    output strength_seen, output last, input ready);
    modport sink   (input valid, input kind, input pulse_width, input pulse_count,
                    input strength_seen, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/gated_pulse_width_capture_top.sv =====
`default_nettype none

// channel   | dir | handshake       | payload
// ----------+-----+-----------------+--------------------------------------------------
// i_in      | in  | valid / ready   | mode, strength_dbm, level
// o_out     | out | valid / ready   | kind, pulse_width, pulse_count, strength_seen, last
// i_cfg_*   | in  | i_cfg_we only   | i_cfg_idx, i_cfg_data
//
// one item per cycle while the result queue has room; an item is registered at transfer and
// its results are registered into the result queue as it leaves the input register
// an item that yields a pulse and a done result needs two output transfers
// input stalls while an item waits in the input register and the 4-entry result queue has fewer than two free slots
// synchronous active-low reset clears capture state and loads register defaults

module gated_pulse_width_capture_top
    import gpwc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    gpwc_in_if.sink                    i_in,
    gpwc_out_if.source                 o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // config registers
    t_cfg r_cfg;

    // input register
    logic  r_in_valid;
    t_item r_in_item;

    // core to queue
    logic [1:0]          core_push;
    t_result             core_res0;
    t_result             core_res1;
    t_result             q_head;
    logic                q_valid;
    logic [RQ_CNT_W-1:0] q_count;

    logic advance;
    logic in_xfer;

    // hand the registered item on only when the queue can hold both results
    assign advance     = r_in_valid && (q_count <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign i_in.ready  = !r_in_valid || advance;
    assign in_xfer     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= '{mode: i_in.mode, strength_dbm: i_in.strength_dbm,
                           level: i_in.level};
        end
    end

    // register writes, unknown index dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rssi_threshold  <= RSSI_THRESHOLD_RST;
            r_cfg.min_pulse_ticks <= MIN_PULSE_TICKS_RST;
            r_cfg.window_ticks    <= WINDOW_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RSSI_THRESHOLD:  r_cfg.rssi_threshold  <= i_cfg_data[STR_W-1:0];
                REG_MIN_PULSE_TICKS: r_cfg.min_pulse_ticks <= i_cfg_data[MIN_W-1:0];
                REG_WINDOW_TICKS:    r_cfg.window_ticks    <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // capture state and result forming
    gpwc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (advance),
        .i_item  (r_in_item),
        .i_cfg   (r_cfg),
        .o_push  (core_push),
        .o_res0  (core_res0),
        .o_res1  (core_res1)
    );

    // results wait here until the sink takes them
    gpwc_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (core_push),
        .i_res0  (core_res0),
        .i_res1  (core_res1),
        .i_pop   (o_out.ready),
        .o_valid (q_valid),
        .o_head  (q_head),
        .o_count (q_count)
    );

    assign o_out.valid         = q_valid;
    assign o_out.kind          = q_head.kind;
    assign o_out.pulse_width   = q_head.pulse_width;
    assign o_out.pulse_count   = q_head.pulse_count;
    assign o_out.strength_seen = q_head.strength_seen;
    assign o_out.last          = q_head.last;

    // a pulse result never ends the run and always counts itself
    a_pulse_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && q_head.kind == KIND_PULSE) |-> (!o_out.last && o_out.pulse_count != '0))
        else $error("malformed pulse result");

endmodule

`default_nettype wire

// ===== rtl/gpwc_core.sv =====
`default_nettype none

module gpwc_core
    import gpwc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output logic [1:0] o_push,
    output t_result    o_res0,
    output t_result    o_res1
);

    logic                    r_capturing, n_capturing;
    logic                    r_prev_level, n_prev_level;
    logic [WIN_W-1:0]        r_elapsed, n_elapsed;
    logic [WIN_W-1:0]        r_edge_tick, n_edge_tick;
    logic [CNT_W-1:0]        r_captured, n_captured;
    logic signed [STR_W-1:0] r_latched, n_latched;

    logic [WIN_W:0]   elapsed_inc;
    logic [WIN_W-1:0] delta;
    logic [PW_W-1:0]  width_sat;
    logic             pulse_hit;

    assign elapsed_inc = {1'b0, r_elapsed} + {{WIN_W{1'b0}}, 1'b1};
    assign delta       = r_elapsed - r_edge_tick;
    assign width_sat   = (|delta[WIN_W-1:PW_W]) ? {PW_W{1'b1}} : delta[PW_W-1:0];
    assign pulse_hit   = delta > {{(WIN_W-MIN_W){1'b0}}, i_cfg.min_pulse_ticks};

    always_comb begin
        n_capturing  = r_capturing;
        n_prev_level = r_prev_level;
        n_elapsed    = r_elapsed;
        n_edge_tick  = r_edge_tick;
        n_captured   = r_captured;
        n_latched    = r_latched;
        o_push       = 2'd0;
        o_res0       = '{kind: KIND_DONE, pulse_width: '0, pulse_count: '0,
                         strength_seen: r_latched, last: 1'b1};
        o_res1       = o_res0;

        if (i_valid) begin
            if (i_item.mode == MODE_START) begin
                n_latched            = i_item.strength_dbm;
                o_res0.strength_seen = i_item.strength_dbm;
                if ($signed(i_item.strength_dbm) <= $signed(i_cfg.rssi_threshold)) begin
                    n_capturing = 1'b0;
                    o_res0.kind = KIND_REJECT;
                    o_push      = 2'd1;
                end else begin
                    n_capturing  = 1'b1;
                    n_prev_level = i_item.level;
                    n_elapsed    = '0;
                    n_edge_tick  = '0;
                    n_captured   = '0;
                    // zero window ends at once
                    if (i_cfg.window_ticks == '0) begin
                        n_capturing = 1'b0;
                        o_push      = 2'd1;
                    end
                end
            end else if (r_capturing) begin
                n_elapsed = elapsed_inc[WIN_W-1:0];
                if (i_item.level != r_prev_level) begin
                    n_edge_tick  = r_elapsed;
                    n_prev_level = i_item.level;
                    if (pulse_hit) begin
                        n_captured = r_captured + CNT_W'(1);
                        o_res0     = '{kind: KIND_PULSE, pulse_width: width_sat,
                                       pulse_count: n_captured,
                                       strength_seen: r_latched, last: 1'b0};
                        o_push     = 2'd1;
                    end
                end
                if (elapsed_inc >= {1'b0, i_cfg.window_ticks}
                        || n_captured >= CNT_W'(MAX_PULSE_COUNT)) begin
                    n_capturing = 1'b0;
                    if (o_push == 2'd1) begin
                        o_res1.pulse_count = n_captured;
                        o_push             = 2'd2;
                    end else begin
                        o_res0.pulse_count = n_captured;
                        o_push             = 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capturing  <= 1'b0;
            r_prev_level <= 1'b0;
            r_elapsed    <= '0;
            r_edge_tick  <= '0;
            r_captured   <= '0;
            r_latched    <= '0;
        end else begin
            r_capturing  <= n_capturing;
            r_prev_level <= n_prev_level;
            r_elapsed    <= n_elapsed;
            r_edge_tick  <= n_edge_tick;
            r_captured   <= n_captured;
            r_latched    <= n_latched;
        end
    end

    a_end_clears_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && ((o_push == 2'd1 && o_res0.last) || (o_push == 2'd2 && o_res1.last)))
        |=> !r_capturing)
        else $error("capture still armed after a final result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_captured <= CNT_W'(MAX_PULSE_COUNT))
        else $error("pulse count above limit");

    a_edge_not_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_capturing |-> r_edge_tick <= r_elapsed)
        else $error("edge reference ahead of elapsed time");

endmodule

`default_nettype wire

// ===== rtl/gpwc_res_fifo.sv =====
`default_nettype none

module gpwc_res_fifo
    import gpwc_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [1:0]    i_push,
    input  wire t_result       i_res0,
    input  wire t_result       i_res1,
    input  wire logic          i_pop,
    output logic               o_valid,
    output t_result            o_head,
    output logic [RQ_CNT_W-1:0] o_count
);

    t_result               r_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [RQ_PTR_W-1:0]   r_rd_ptr;
    logic [RQ_CNT_W-1:0]   r_count, n_count;
    logic                  pop_ok;

    assign pop_ok   = i_pop && (r_count != '0);
    assign n_wr_ptr = r_wr_ptr + RQ_PTR_W'(i_push);
    assign n_count  = r_count + RQ_CNT_W'(i_push) - RQ_CNT_W'(pop_ok);

    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push == 2'd2) begin
            r_mem[r_wr_ptr + RQ_PTR_W'(1)] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + RQ_PTR_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RQ_CNT_W'(RQ_DEPTH))
        else $error("result queue overflow");

endmodule

`default_nettype wire
